// ===== sv/kps_pkg.sv =====
package kps_pkg;

    localparam int TICK_W   = 20;
    localparam int SETTLE_W = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [TICK_W-1:0]   DEBOUNCE_RESET = TICK_W'(20000);
    localparam logic [SETTLE_W-1:0] SETTLE_RESET   = SETTLE_W'(5);
    localparam logic [TICK_W-1:0]   RELEASE_RESET  = TICK_W'(10000);

    // register index = paddr[3:2]
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_SETTLE   = 2'd1;
    localparam logic [1:0] REG_RELEASE  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_SCAN     = 3'd2,
        PH_COLUMN   = 3'd3,
        PH_RELEASE  = 3'd4,
        PH_POST     = 3'd5
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0]   debounce_ticks;
        logic [SETTLE_W-1:0] settle_ticks;
        logic [TICK_W-1:0]   release_ticks;
    } cfg_t;

    typedef struct packed {
        logic [3:0] row_levels;
        logic       key_strobe;
        logic [7:0] key_code;
    } result_t;

    // 4x4 keypad legend, row-major
    function automatic logic [7:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
        logic [7:0] code;
        begin
            code = 8'h00;
            case ({row, col})
                4'h0: code = "1";
                4'h1: code = "2";
                4'h2: code = "3";
                4'h3: code = "A";
                4'h4: code = "4";
                4'h5: code = "5";
                4'h6: code = "6";
                4'h7: code = "B";
                4'h8: code = "7";
                4'h9: code = "8";
                4'hA: code = "9";
                4'hB: code = "C";
                4'hC: code = "*";
                4'hD: code = "0";
                4'hE: code = "#";
                default: code = "D";
            endcase
            return code;
        end
    endfunction

endpackage

// ===== sv/kps_cfg.sv =====
module kps_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kps_pkg::ADDR_W-1:0] paddr,
    input  logic [kps_pkg::DATA_W-1:0] pwdata,
    output logic [kps_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output kps_pkg::cfg_t              cfg
);
    import kps_pkg::*;

    logic [TICK_W-1:0]   debounce_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [TICK_W-1:0]   release_reg;
    logic                wr_en;
    logic [1:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            settle_reg   <= SETTLE_RESET;
            release_reg  <= RELEASE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DEBOUNCE: debounce_reg <= pwdata[TICK_W-1:0];
                REG_SETTLE:   settle_reg   <= pwdata[SETTLE_W-1:0];
                REG_RELEASE:  release_reg  <= pwdata[TICK_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DEBOUNCE: prdata = DATA_W'(debounce_reg);
            REG_SETTLE:   prdata = DATA_W'(settle_reg);
            REG_RELEASE:  prdata = DATA_W'(release_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg = '{debounce_ticks: debounce_reg,
                   settle_ticks:   settle_reg,
                   release_ticks:  release_reg};

endmodule

// ===== sv/kps_step.sv =====
module kps_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [3:0]       column_levels,
    input  kps_pkg::cfg_t    cfg,
    output kps_pkg::result_t res
);
    import kps_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [1:0]        row_reg, row_next;
    logic [7:0]        held_reg, held_next;

    logic              any_low;
    logic [TICK_W-1:0] limit;
    logic              wait_over;
    logic              col_found;
    logic [1:0]        col_idx;

    assign any_low = (column_levels != 4'hF);

    // lowest column pulled low
    always_comb
    begin
        col_found = 1'b1;
        col_idx   = 2'd0;
        if (!column_levels[0])      col_idx = 2'd0;
        else if (!column_levels[1]) col_idx = 2'd1;
        else if (!column_levels[2]) col_idx = 2'd2;
        else if (!column_levels[3]) col_idx = 2'd3;
        else                        col_found = 1'b0;
    end

    always_comb
    begin
        case (phase_reg)
            PH_DEBOUNCE: limit = cfg.debounce_ticks;
            PH_SCAN:     limit = TICK_W'(cfg.settle_ticks);
            default:     limit = cfg.release_ticks;
        endcase
    end

    assign wait_over = (tick_reg >= limit);

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        row_next   = row_reg;
        held_next  = held_reg;
        res.key_strobe = 1'b0;
        res.key_code   = 8'h00;

        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                if (!wait_over)
                    tick_next = tick_reg + 1'b1;
                else
                begin
                    tick_next = '0;
                    if (any_low)
                    begin
                        phase_next = PH_SCAN;
                        row_next   = 2'd0;
                    end
                    else
                        phase_next = PH_IDLE;
                end
            end
            PH_SCAN:
            begin
                if (!wait_over)
                    tick_next = tick_reg + 1'b1;
                else
                begin
                    tick_next = '0;
                    if (any_low)
                        phase_next = PH_COLUMN;
                    else if (row_reg == 2'd3)
                    begin
                        phase_next = PH_IDLE;   // phantom row
                        row_next   = 2'd0;
                    end
                    else
                        row_next = row_reg + 2'd1;
                end
            end
            PH_COLUMN:
            begin
                if (!col_found)
                    phase_next = PH_IDLE;       // phantom column
                else
                begin
                    held_next  = key_lookup(row_reg, col_idx);
                    phase_next = PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                if (!any_low)
                begin
                    phase_next = PH_POST;
                    tick_next  = '0;
                end
            end
            PH_POST:
            begin
                if (!wait_over)
                    tick_next = tick_reg + 1'b1;
                else
                begin
                    tick_next      = '0;
                    res.key_strobe = 1'b1;
                    res.key_code   = held_reg;
                    phase_next     = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (any_low)
                begin
                    phase_next = PH_DEBOUNCE;
                    tick_next  = '0;
                end
            end
        endcase

        if (phase_next == PH_SCAN)
            res.row_levels = ~(4'b0001 << row_next);
        else
            res.row_levels = 4'h0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            row_reg   <= 2'd0;
            held_reg  <= 8'h00;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            row_reg   <= row_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== sv/kps_out.sv =====
module kps_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  kps_pkg::result_t res,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             free,
    output kps_pkg::result_t res_out
);
    import kps_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // slot can take a new result when empty or drained this cycle
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

// ===== sv/matrix_keypad_scanner_core.sv =====
// 4x4 matrix keypad scanner. Each input transaction is one timebase tick carrying the four
// sampled column pins (0 = pulled low); each produces exactly one output transaction with the
// row drive to hold until the next tick, a key strobe and the key's ASCII code (zero when no
// strobe). Sequence: idle with all rows low, debounce wait, row-by-row scan with a settle
// wait per row, column pick (lowest low column), wait for release, post-release wait, strobe.
// Noise at debounce and phantom rows or columns return to idle. Throughput is one tick per
// clock while the output register is empty or being emptied: the step logic works from the
// phase/counter registers straight into the output register, so each result shows in the
// next cycle. Wait lengths are set through the APB port (debounce at 0x0, settle at 0x4,
// release at 0x8); new values apply immediately, so write them while idle.
module matrix_keypad_scanner_core (
    input  logic                       clk,
    input  logic                       rst_n,
    // tick input
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [3:0]                 column_levels,
    // result output
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [3:0]                 row_levels,
    output logic                       key_strobe,
    output logic [7:0]                 key_code,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kps_pkg::ADDR_W-1:0] paddr,
    input  logic [kps_pkg::DATA_W-1:0] pwdata,
    output logic [kps_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import kps_pkg::*;

    cfg_t    cfg;
    result_t step_res;
    result_t out_res;
    logic    slot_free;
    logic    accept;

    assign in_ready = slot_free;
    assign accept   = in_valid && slot_free;

    kps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // scan state advances only on an accepted tick transaction
    kps_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .column_levels (column_levels),
        .cfg           (cfg),
        .res           (step_res)
    );

    kps_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res       (step_res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (slot_free),
        .res_out   (out_res)
    );

    assign row_levels = out_res.row_levels;
    assign key_strobe = out_res.key_strobe;
    assign key_code   = out_res.key_code;

endmodule

// ===== sv/kps_checker.sv =====
module kps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] row_levels,
    input logic       key_strobe,
    input logic [7:0] key_code
);

    // held result must not vanish
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // an empty output stage never stalls the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // every accepted tick shows a result on the next cycle
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick gave no result");

    // at most one row driven high-to-low apart from the all-low idle drive
    a_row_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_levels == 4'h0) || $onehot(~row_levels))
        else $error("illegal row drive pattern");

    // strobe only with all rows low and a real code; no code without strobe
    a_strobe_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_strobe ? (row_levels == 4'h0 && key_code != 8'h00)
                                  : (key_code == 8'h00)))
        else $error("strobe and key code disagree");

endmodule

bind matrix_keypad_scanner_core kps_checker u_kps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_levels (row_levels),
    .key_strobe (key_strobe),
    .key_code   (key_code)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the 4x4 keypad scanner core.
// Every input transaction is one timebase tick and yields exactly one output
// transaction, so the bench keeps a queue of predicted results, one entry per
// accepted tick, and the monitor pops it in order.
module tb;

    import kps_pkg::*;

    localparam int          LIMIT       = 400000;   // cycle budget for the whole run
    localparam int          HOLD_CYCLES = 400;      // long receiver hold-off
    localparam logic [1:0]  REG_SPARE   = 2'd3;     // no register behind this index
    localparam logic [0:15][7:0] KEY_MAP = "123A456B789C*0#D";  // index {row, col}

    localparam result_t QUIET    = {4'h0, 1'b0, 8'h00};
    localparam result_t STROBE_D = {4'h0, 1'b1, "D"};
    localparam result_t NO_RES   = '0;

    // One row of the directed walk: column pins, and a typed-in result where
    // it is obvious by inspection (otherwise the predictor decides).
    typedef struct packed {
        logic [3:0] cols;
        logic       has_res;
        result_t    res;
    } dir_row_t;

    localparam int DIR_N = 22;
    // All waits are zero for this walk, so each tick moves one step.
    localparam dir_row_t [0:DIR_N-1] DIR_TAB = {
        {4'hF, 1'b1, QUIET},     // idle, nothing pressed
        {4'hE, 1'b0, NO_RES},    // press seen, into debounce
        {4'hF, 1'b0, NO_RES},    // gone at debounce: noise, back to idle
        {4'h0, 1'b0, NO_RES},    // every column low
        {4'h0, 1'b0, NO_RES},    // confirmed, scan row 0
        {4'hF, 1'b0, NO_RES},    // row 1
        {4'hF, 1'b0, NO_RES},    // row 2
        {4'hF, 1'b0, NO_RES},    // row 3
        {4'hF, 1'b0, NO_RES},    // no row answered: phantom row, idle
        {4'hE, 1'b0, NO_RES},
        {4'hE, 1'b0, NO_RES},    // scan row 0
        {4'hE, 1'b0, NO_RES},    // row 0 answers, column pick next
        {4'hF, 1'b0, NO_RES},    // nothing low any more: phantom column
        {4'h7, 1'b0, NO_RES},    // key at row 3, column 3
        {4'h7, 1'b0, NO_RES},
        {4'hF, 1'b0, NO_RES},
        {4'hF, 1'b0, NO_RES},
        {4'hF, 1'b0, NO_RES},
        {4'h7, 1'b0, NO_RES},    // row 3 answers
        {4'h7, 1'b0, NO_RES},    // column 3 picked, wait for release
        {4'hF, 1'b0, NO_RES},    // released, post-release wait
        {4'hF, 1'b1, STROBE_D}   // strobe of the bottom-right key
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [3:0]          column_levels;
    logic                out_valid;
    logic                out_ready;
    logic [3:0]          row_levels;
    logic                key_strobe;
    logic [7:0]          key_code;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // predictor state and its copy of the wait registers
    cfg_t                wait_cfg;
    phase_t              kp_phase;
    logic [TICK_W-1:0]   kp_count;
    logic [2:0]          kp_row;
    logic [7:0]          kp_held;
    logic [3:0]          drive_rows;     // row drive of the latest predicted tick

    result_t             tick_results_q[$];

    // keypad model used by the random stimulus
    int unsigned         gap_left;
    int unsigned         hold_left;
    logic [1:0]          pr_row, pr_col, gh_row, gh_col;
    logic                ghost_on;

    int                  burst_left;
    bit                  hold_req;
    int                  mismatches;
    int                  cycle_no;

    matrix_keypad_scanner_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .column_levels (column_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .row_levels    (row_levels),
        .key_strobe    (key_strobe),
        .key_code      (key_code),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Cycle budget: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_no = cycle_no + 1;
        if (cycle_no > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches = mismatches + 1;
        $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    // One wait step; true once the count has reached the limit.
    function automatic logic wait_over(input logic [TICK_W-1:0] limit);
        if (kp_count < limit)
        begin
            kp_count = kp_count + 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the scanner by one tick and return the result it must give.
    function automatic result_t keypad_tick(input logic [3:0] cols);
        result_t r;
        logic    any_low;
        logic    found;
        logic [1:0] col;
        r       = '0;
        any_low = (cols != 4'hF);
        found   = 1'b0;
        col     = 2'd0;
        case (kp_phase)
            PH_DEBOUNCE:
            begin
                if (wait_over(wait_cfg.debounce_ticks))
                begin
                    kp_count = '0;
                    if (any_low)
                    begin
                        kp_phase = PH_SCAN;
                        kp_row   = 3'd0;
                    end
                    else
                        kp_phase = PH_IDLE;
                end
            end
            PH_SCAN:
            begin
                if (wait_over({12'd0, wait_cfg.settle_ticks}))
                begin
                    kp_count = '0;
                    if (any_low)
                        kp_phase = PH_COLUMN;
                    else if (kp_row >= 3'd3)
                    begin
                        kp_phase = PH_IDLE;
                        kp_row   = 3'd0;
                    end
                    else
                        kp_row = kp_row + 3'd1;
                end
            end
            PH_COLUMN:
            begin
                // lowest low column wins
                for (int c = 3; c >= 0; c--)
                begin
                    if (!cols[c])
                    begin
                        found = 1'b1;
                        col   = 2'(c);
                    end
                end
                if (!found)
                    kp_phase = PH_IDLE;
                else
                begin
                    kp_held  = KEY_MAP[{kp_row[1:0], col}];
                    kp_phase = PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                if (!any_low)
                begin
                    kp_phase = PH_POST;
                    kp_count = '0;
                end
            end
            PH_POST:
            begin
                if (wait_over(wait_cfg.release_ticks))
                begin
                    kp_count     = '0;
                    r.key_strobe = 1'b1;
                    r.key_code   = kp_held;
                    kp_phase     = PH_IDLE;
                end
            end
            default:
            begin
                kp_phase = PH_IDLE;
                if (any_low)
                begin
                    kp_phase = PH_DEBOUNCE;
                    kp_count = '0;
                end
            end
        endcase
        r.row_levels = (kp_phase == PH_SCAN) ? ~(4'b0001 << kp_row[1:0]) : 4'h0;
        drive_rows   = r.row_levels;
        return r;
    endfunction

    // Physical keypad: a held key pulls its column low only while its row is
    // driven low by the row drive of the previous tick. Sessions are a gap,
    // then a press mostly long enough to get through the scan, sometimes a
    // second key, and now and then a tick of pure noise.
    function automatic logic [3:0] next_columns();
        logic [3:0]  cols;
        int unsigned needed;
        cols = 4'hF;
        if (gap_left > 0)
            gap_left = gap_left - 1;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            if (!drive_rows[pr_row])
                cols[pr_col] = 1'b0;
            if (ghost_on && !drive_rows[gh_row])
                cols[gh_col] = 1'b0;
        end
        else
        begin
            needed    = int'(wait_cfg.debounce_ticks) + 4 * (int'(wait_cfg.settle_ticks) + 1) + 4;
            pr_row    = 2'($urandom_range(0, 3));
            pr_col    = 2'($urandom_range(0, 3));
            gh_row    = 2'($urandom_range(0, 3));
            gh_col    = 2'($urandom_range(0, 3));
            ghost_on  = ($urandom_range(0, 9) == 0);
            hold_left = ($urandom_range(0, 9) < 8) ? needed + $urandom_range(0, 8)
                                                   : $urandom_range(0, needed);
            // short gaps land new presses inside the post-release wait
            gap_left  = $urandom_range(0, int'(wait_cfg.release_ticks) + 4);
        end
        if ($urandom_range(0, 24) == 0)
            cols = 4'($urandom_range(0, 15));
        return cols;
    endfunction

    // Offer one tick transaction; called at a falling edge. The sender runs in
    // bursts with random gaps, and long bursts give stretches with no idling.
    task automatic send_tick(input logic [3:0] cols, input logic has_res, input result_t res);
        result_t pred;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        burst_left    = burst_left - 1;
        in_valid      <= 1'b1;
        column_levels <= cols;
        do
            @(posedge clk);
        while (!in_ready);
        pred = keypad_tick(cols);
        tick_results_q.push_back(has_res ? res : pred);
        @(negedge clk);
    endtask

    task automatic run_random(input int n);
        gap_left  = 0;
        hold_left = 0;
        repeat (n) send_tick(next_columns(), 1'b0, NO_RES);
    endtask

    // Stop offering and wait for every predicted result to come out.
    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (tick_results_q.size() != 0);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_DEBOUNCE: wait_cfg.debounce_ticks = data[TICK_W-1:0];
            REG_SETTLE:   wait_cfg.settle_ticks   = data[SETTLE_W-1:0];
            REG_RELEASE:  wait_cfg.release_ticks  = data[TICK_W-1:0];
            default:      ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_check(input logic [1:0] idx, input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        if (got !== want)
            report($sformatf("register %0d read", idx), got, want);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Write all three wait lengths (junk in the unused upper bits) and read back.
    task automatic program_waits(input logic [TICK_W-1:0] deb, input logic [SETTLE_W-1:0] stl,
                                 input logic [TICK_W-1:0] rel);
        apb_write(REG_DEBOUNCE, {12'($urandom), deb});
        apb_write(REG_SETTLE,   {24'($urandom), stl});
        apb_write(REG_RELEASE,  {12'($urandom), rel});
        apb_check(REG_DEBOUNCE, DATA_W'(deb));
        apb_check(REG_SETTLE,   DATA_W'(stl));
        apb_check(REG_RELEASE,  DATA_W'(rel));
    endtask

    // Receiver: stalls on a random 8-bit mask walked bit by bit and redrawn after eight passes,
    // some windows fully ready; on request it holds off for a long stretch so the
    // core fills and back-pressures the tick input.
    initial
    begin
        int         slot;
        int         stall_left;
        logic [7:0] mask;
        slot       = 0;
        stall_left = 0;
        mask       = 8'hFF;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                if (slot == 0)
                    mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
                out_ready <= mask[slot % 8];
                slot      = (slot + 1) % 64;
            end
        end
    end

    // Monitor: each output transaction against the oldest prediction.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {row_levels, key_strobe, key_code};
            if (tick_results_q.size() == 0)
                report("result with nothing pending", 32'(got), 32'h0);
            else
            begin
                want = tick_results_q.pop_front();
                if (got.row_levels !== want.row_levels)
                    report("row_levels", 32'(got.row_levels), 32'(want.row_levels));
                if (got.key_strobe !== want.key_strobe)
                    report("key_strobe", 32'(got.key_strobe), 32'(want.key_strobe));
                if (got.key_code !== want.key_code)
                    report("key_code", 32'(got.key_code), 32'(want.key_code));
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        column_levels = 4'hF;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_req      = 1'b0;
        mismatches    = 0;
        cycle_no      = 0;
        burst_left    = 0;
        gap_left      = 0;
        hold_left     = 0;
        ghost_on      = 1'b0;
        pr_row        = 2'd0;
        pr_col        = 2'd0;
        gh_row        = 2'd0;
        gh_col        = 2'd0;
        wait_cfg      = {DEBOUNCE_RESET, SETTLE_RESET, RELEASE_RESET};
        kp_phase      = PH_IDLE;
        kp_count      = '0;
        kp_row        = 3'd0;
        kp_held       = 8'h00;
        drive_rows    = 4'h0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values of the wait registers
        apb_check(REG_DEBOUNCE, DATA_W'(DEBOUNCE_RESET));
        apb_check(REG_SETTLE,   DATA_W'(SETTLE_RESET));
        apb_check(REG_RELEASE,  DATA_W'(RELEASE_RESET));

        // directed walk with zero waits
        program_waits(20'd0, 8'd0, 20'd0);
        for (int i = 0; i < DIR_N; i++)
            send_tick(DIR_TAB[i].cols, DIR_TAB[i].has_res, DIR_TAB[i].res);
        drain_results();

        run_random(350);
        drain_results();

        // short waits; a write to the unmapped index must change nothing
        apb_write(REG_SPARE, $urandom);
        program_waits(20'($urandom_range(1, 6)), 8'($urandom_range(1, 3)),
                      20'($urandom_range(1, 6)));
        hold_req = 1'b1;
        run_random(350);
        drain_results();

        // longest settle time
        program_waits(20'd2, 8'd255, 20'd3);
        run_random(500);
        drain_results();

        program_waits(20'($urandom_range(0, 10)), 8'($urandom_range(0, 4)),
                      20'($urandom_range(0, 10)));
        run_random(350);
        drain_results();

        // longest debounce and release waits, idle ticks only
        program_waits(20'hFFFFF, 8'd0, 20'hFFFFF);
        repeat (20) send_tick(4'hF, 1'b0, NO_RES);
        drain_results();

        program_waits(20'd5, 8'd1, 20'd5);
        run_random(350);
        drain_results();

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/kps_pkg.sv
sv/kps_cfg.sv
sv/kps_step.sv
sv/kps_out.sv
sv/matrix_keypad_scanner_core.sv
sv/kps_checker.sv
tb/sv/tb.sv
